FILE: rtl/core/qprm_pkg.sv
// Package: types, codes and sizes for the queue pair ring manager.
package qprm_pkg;

   localparam int MAX_ENTRIES  = 1024;
   localparam int ADDRESS_BITS = 32;
   localparam int IDX_W        = $clog2(MAX_ENTRIES);
   localparam int COUNT_W      = 11;
   localparam int SIZE_W       = 13;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int PROD_W       = IDX_W + SIZE_W;

   localparam logic [COUNT_W-1:0] MIN_COUNT = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_ENTRIES);

   localparam logic [1:0] OP_RESERVE = 2'd0;
   localparam logic [1:0] OP_SUBMIT  = 2'd1;
   localparam logic [1:0] OP_PEEK    = 2'd2;
   localparam logic [1:0] OP_CONSUME = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_MISMATCH = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SQ_BASE       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CQ_BASE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SQ_ENTRY_SIZE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CQ_ENTRY_SIZE = 3'd4;

   localparam logic [COUNT_W-1:0] RST_ENTRY_COUNT   = COUNT_W'(16);
   localparam logic [SIZE_W-1:0]  RST_SQ_ENTRY_SIZE = SIZE_W'(64);
   localparam logic [SIZE_W-1:0]  RST_CQ_ENTRY_SIZE = SIZE_W'(16);

   typedef struct packed {
      logic [1:0]              operation;
      logic                    ring_select;
      logic [ADDRESS_BITS-1:0] entry_address;
   } req_type;

   typedef struct packed {
      logic [ADDRESS_BITS-1:0] slot_address;
      logic [1:0]              status;
   } rsp_type;

endpackage

FILE: rtl/core/queue_pair_ring_manager_top.sv
// Top level: submission/completion queue pair ring manager.
//
// Usage:
//  - Request channel: drive req_data and raise start; the item is taken at a
//    rising edge with start high and busy low. One item may enter every cycle.
//  - Result channel: rsp_strobe marks rsp_data for exactly one cycle; the
//    receiver cannot stall, so every result must be captured when strobed.
//  - CSR port: csr_we writes csr_wdata into register csr_index at the edge;
//    unknown indexes are ignored. Write only while no item is in flight.
//  - Timing: rsp_strobe rises at the edge following the accepting edge (input
//    register, then the result register). Throughput is one item per cycle;
//    ring indexes update in the compute cycle, so back-to-back items see each
//    other's effect.
//  - The compute cycle holds one 10x13 multiply feeding a 32-bit add and
//    compare, which sets the cycle time.
//  - Reset: all ring indexes clear, CSRs take their defaults, in-flight items
//    are dropped, and busy stays high until the first edge after reset drops.
module queue_pair_ring_manager_top
   import qprm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                    busy_ff;
   logic                    req_vld_ff;
   req_type                 req_ff;
   logic                    rsp_vld_ff;
   rsp_type                 rsp_ff, rsp_in;

   logic [COUNT_W-1:0]      entry_count_ff;
   logic [ADDRESS_BITS-1:0] sq_base_ff, cq_base_ff;
   logic [SIZE_W-1:0]       sq_entry_size_ff, cq_entry_size_ff;

   logic [IDX_W-1:0]        sq_head_ff, sq_tail_ff, cq_head_ff, cq_tail_ff;
   logic [IDX_W-1:0]        sq_head_in, sq_tail_in, cq_head_in, cq_tail_in;

   logic [COUNT_W-1:0]      eff_count;
   logic [IDX_W-1:0]        head, tail, idx_sel, idx_next;
   logic [COUNT_W-1:0]      idx_inc;
   logic [IDX_W-1:0]        tail_next;
   logic [COUNT_W-1:0]      tail_inc;
   logic [ADDRESS_BITS-1:0] base;
   logic [SIZE_W-1:0]       size;
   logic [PROD_W-1:0]       offset;
   logic [ADDRESS_BITS-1:0] slot;
   logic                    full, empty, addr_ok;
   logic                    adv_tail, adv_head;

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      if (entry_count_ff < MIN_COUNT) begin
         eff_count = MIN_COUNT;
      end else if (entry_count_ff > MAX_COUNT) begin
         eff_count = MAX_COUNT;
      end else begin
         eff_count = entry_count_ff;
      end
   end

   assign head = req_ff.ring_select ? cq_head_ff : sq_head_ff;
   assign tail = req_ff.ring_select ? cq_tail_ff : sq_tail_ff;
   assign base = req_ff.ring_select ? cq_base_ff : sq_base_ff;
   assign size = req_ff.ring_select ? cq_entry_size_ff : sq_entry_size_ff;

   // head for peek/consume, tail for reserve/submit
   assign idx_sel = req_ff.operation[1] ? head : tail;

   assign tail_inc  = {1'b0, tail} + COUNT_W'(1);
   assign tail_next = (tail_inc >= eff_count) ? '0 : tail_inc[IDX_W-1:0];
   assign idx_inc   = {1'b0, idx_sel} + COUNT_W'(1);
   assign idx_next  = (idx_inc >= eff_count) ? '0 : idx_inc[IDX_W-1:0];

   assign full    = (tail_next == tail) ? 1'b0 : (tail_next == head);
   assign empty   = (head == tail);
   assign offset  = PROD_W'(idx_sel) * PROD_W'(size);
   assign slot    = base + ADDRESS_BITS'(offset);
   assign addr_ok = (req_ff.entry_address == slot);

   always_comb begin
      rsp_in   = '{slot_address: '0, status: ST_OK};
      adv_tail = 1'b0;
      adv_head = 1'b0;
      unique case (req_ff.operation)
         OP_RESERVE: begin
            if (full) rsp_in.status = ST_FULL;
            else      rsp_in.slot_address = slot;
         end
         OP_SUBMIT: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else if (!addr_ok) begin
               rsp_in.status = ST_MISMATCH;
            end else begin
               rsp_in.slot_address = slot;
               adv_tail = req_vld_ff;
            end
         end
         OP_PEEK: begin
            if (empty) rsp_in.status = ST_EMPTY;
            else       rsp_in.slot_address = slot;
         end
         OP_CONSUME: begin
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else if (!addr_ok) begin
               rsp_in.status = ST_MISMATCH;
            end else begin
               rsp_in.slot_address = slot;
               adv_head = req_vld_ff;
            end
         end
         default: begin
            rsp_in.status = ST_OK;
         end
      endcase
   end

   always_comb begin
      sq_head_in = sq_head_ff;
      sq_tail_in = sq_tail_ff;
      cq_head_in = cq_head_ff;
      cq_tail_in = cq_tail_ff;
      if (adv_tail) begin
         if (req_ff.ring_select) cq_tail_in = idx_next;
         else                    sq_tail_in = idx_next;
      end
      if (adv_head) begin
         if (req_ff.ring_select) cq_head_in = idx_next;
         else                    sq_head_in = idx_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b1;
         req_vld_ff       <= 1'b0;
         rsp_vld_ff       <= 1'b0;
         sq_head_ff       <= '0;
         sq_tail_ff       <= '0;
         cq_head_ff       <= '0;
         cq_tail_ff       <= '0;
         entry_count_ff   <= RST_ENTRY_COUNT;
         sq_base_ff       <= '0;
         cq_base_ff       <= '0;
         sq_entry_size_ff <= RST_SQ_ENTRY_SIZE;
         cq_entry_size_ff <= RST_CQ_ENTRY_SIZE;
      end else begin
         busy_ff    <= 1'b0;
         req_vld_ff <= start && !busy_ff;
         rsp_vld_ff <= req_vld_ff;
         sq_head_ff <= sq_head_in;
         sq_tail_ff <= sq_tail_in;
         cq_head_ff <= cq_head_in;
         cq_tail_ff <= cq_tail_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_ENTRY_COUNT:   entry_count_ff   <= csr_wdata[COUNT_W-1:0];
               CSR_SQ_BASE:       sq_base_ff       <= csr_wdata[ADDRESS_BITS-1:0];
               CSR_CQ_BASE:       cq_base_ff       <= csr_wdata[ADDRESS_BITS-1:0];
               CSR_SQ_ENTRY_SIZE: sq_entry_size_ff <= csr_wdata[SIZE_W-1:0];
               CSR_CQ_ENTRY_SIZE: cq_entry_size_ff <= csr_wdata[SIZE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         req_ff <= req_data;
      end
      if (req_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: sim/tb_queue_pair_ring_manager_top.sv
`timescale 1ns / 100ps
// Testbench for queue_pair_ring_manager_top: random ring traffic checked against a predictor.
module tb_queue_pair_ring_manager_top;
   import qprm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int PHASES         = 13;
   localparam int PHASE_ITEMS    = 156;

   typedef struct packed {
      logic [COUNT_W-1:0]          count;
      logic [ADDRESS_BITS-1:0]     sq_base;
      logic [ADDRESS_BITS-1:0]     cq_base;
      logic [SIZE_W-1:0]           sq_size;
      logic [SIZE_W-1:0]           cq_size;
      logic [1:0][IDX_W-1:0]       head;
      logic [1:0][IDX_W-1:0]       tail;
   } ring_state_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_data  = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   req_type        pending_ops [$];
   rsp_type        expected_replies [$];
   ring_state_type plan_st;
   ring_state_type pred_st;
   int unsigned idle_pct       = 0;
   int unsigned items_sent     = 0;
   int unsigned replies_seen   = 0;
   int unsigned fail_count     = 0;
   int unsigned settings_used  = 0;
   int unsigned stall_cycles   = 0;
   int unsigned status_seen [4] = '{default: 0};

   int unsigned count_menu [PHASES] = '{0, 1, 2, 3, 5, 2047, 4, 8, 1024, 16, 7, 1025, 6};
   logic [31:0] base_menu [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_F000,
                                  32'h8000_0000};
   int unsigned size_menu [6] = '{1, 4096, 0, 8191, 64, 3};
   int unsigned idle_menu [4] = '{0, 79, 18, 0};
   int unsigned bias_menu [3] = '{50, 75, 30};

   queue_pair_ring_manager_top u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic ring_state_type reset_state();
      ring_state_type s;
      s = '0;
      s.count   = RST_ENTRY_COUNT;
      s.sq_size = RST_SQ_ENTRY_SIZE;
      s.cq_size = RST_CQ_ENTRY_SIZE;
      return s;
   endfunction

   function automatic ring_state_type with_csr(ring_state_type s,
                                               logic [CSR_IDX_W-1:0] idx,
                                               logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_ENTRY_COUNT:   s.count   = val[COUNT_W-1:0];
         CSR_SQ_BASE:       s.sq_base = val;
         CSR_CQ_BASE:       s.cq_base = val;
         CSR_SQ_ENTRY_SIZE: s.sq_size = val[SIZE_W-1:0];
         CSR_CQ_ENTRY_SIZE: s.cq_size = val[SIZE_W-1:0];
         default: ;
      endcase
      return s;
   endfunction

   function automatic int unsigned slot_limit(ring_state_type s);
      if (s.count < MIN_COUNT) return 2;
      if (s.count > MAX_COUNT) return MAX_ENTRIES;
      return s.count;
   endfunction

   function automatic logic [IDX_W-1:0] next_slot(ring_state_type s,
                                                  logic [IDX_W-1:0] idx);
      if (32'(idx) + 32'd1 >= slot_limit(s)) return '0;
      return idx + 1'b1;
   endfunction

   function automatic logic [31:0] slot_addr(ring_state_type s, logic ring,
                                             logic [IDX_W-1:0] idx);
      if (ring) return s.cq_base + 32'(idx) * 32'(s.cq_size);
      return s.sq_base + 32'(idx) * 32'(s.sq_size);
   endfunction

   task automatic apply_ring_op(inout ring_state_type s, input req_type r, output rsp_type o);
      logic              ring;
      logic [IDX_W-1:0]  hd;
      logic [IDX_W-1:0]  tl;
      logic              full;
      logic              empty;
      ring  = r.ring_select;
      hd    = s.head[ring];
      tl    = s.tail[ring];
      full  = next_slot(s, tl) == hd;
      empty = hd == tl;
      o = '0;
      o.status = ST_OK;
      case (r.operation)
         OP_RESERVE: begin
            if (full) o.status = ST_FULL;
            else o.slot_address = slot_addr(s, ring, tl);
         end
         OP_SUBMIT: begin
            if (full) begin
               o.status = ST_FULL;
            end else if (r.entry_address != slot_addr(s, ring, tl)) begin
               o.status = ST_MISMATCH;
            end else begin
               o.slot_address = r.entry_address;
               s.tail[ring]   = next_slot(s, tl);
            end
         end
         OP_PEEK: begin
            if (empty) o.status = ST_EMPTY;
            else o.slot_address = slot_addr(s, ring, hd);
         end
         OP_CONSUME: begin
            if (empty) begin
               o.status = ST_EMPTY;
            end else if (r.entry_address != slot_addr(s, ring, hd)) begin
               o.status = ST_MISMATCH;
            end else begin
               o.slot_address = r.entry_address;
               s.head[ring]   = next_slot(s, hd);
            end
         end
      endcase
   endtask

   function automatic logic [31:0] plan_slot(logic ring, logic at_head);
      return slot_addr(plan_st, ring, at_head ? plan_st.head[ring] : plan_st.tail[ring]);
   endfunction

   task automatic push_op(input logic [1:0] op, input logic ring, input logic [31:0] addr);
      req_type r;
      rsp_type unused;
      r.operation     = op;
      r.ring_select   = ring;
      r.entry_address = addr;
      pending_ops.push_back(r);
      apply_ring_op(plan_st, r, unused);
   endtask

   // mostly well-formed reserve/submit and peek/consume pairs, some noise and bad addresses
   task automatic plan_random_pair(input int unsigned bias);
      logic        ring;
      logic [31:0] addr;
      int unsigned roll;
      ring = 1'($urandom_range(1));
      roll = $urandom_range(99);
      if (roll < 10) begin
         push_op(2'($urandom_range(3)), ring, $urandom);
      end else if ($urandom_range(99) < bias) begin
         push_op(OP_RESERVE, ring, $urandom);
         addr = plan_slot(ring, 1'b0);
         if (roll < 17) addr = addr ^ (32'd1 << $urandom_range(31));
         push_op(OP_SUBMIT, ring, addr);
      end else begin
         push_op(OP_PEEK, ring, $urandom);
         addr = plan_slot(ring, 1'b1);
         if (roll < 17) addr = addr ^ (32'd1 << $urandom_range(31));
         push_op(OP_CONSUME, ring, addr);
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_ops.size() != 0 || start || expected_replies.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      plan_st = with_csr(plan_st, idx, val);
   endtask

   task automatic close_csr();
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   task automatic report_fail(input string what, input rsp_type want, input rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("ERROR %s at %0t: expected addr %h status %0d, got addr %h status %0d",
                  what, $realtime, want.slot_address, want.status,
                  got.slot_address, got.status);
   endtask

   // driver: predicts each accepted item, then presents the next pending one
   always @(posedge clock) begin : driver
      rsp_type reply;
      if (reset) begin
         start   <= 1'b0;
         pred_st = reset_state();
      end else begin
         if (csr_we) pred_st = with_csr(pred_st, csr_index, csr_wdata);
         if (start && !busy) begin
            apply_ring_op(pred_st, req_data, reply);
            expected_replies.push_back(reply);
            items_sent++;
         end
         if (!start || !busy) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_data <= pending_ops.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            replies_seen++;
            if (!$isunknown(rsp_data.status)) status_seen[rsp_data.status]++;
            if (expected_replies.size() == 0) begin
               report_fail("unexpected result", '0, rsp_data);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_data.slot_address !== want.slot_address ||
                   rsp_data.status !== want.status)
                  report_fail("result mismatch", want, rsp_data);
            end
         end
         if ((start && !busy) || rsp_strobe) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [31:0] val;
      plan_st = reset_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults: empty checks, bad addresses, good submit/consume on both rings
      push_op(OP_PEEK,    1'b0, 32'h0000_0000);
      push_op(OP_CONSUME, 1'b0, 32'h0000_0000);
      push_op(OP_RESERVE, 1'b0, 32'hFFFF_FFFF);
      push_op(OP_SUBMIT,  1'b0, 32'hFFFF_FFFF);
      push_op(OP_SUBMIT,  1'b0, 32'h0000_0000);
      push_op(OP_PEEK,    1'b0, 32'h0000_0000);
      push_op(OP_CONSUME, 1'b0, 32'h0000_0040);
      push_op(OP_CONSUME, 1'b0, 32'h0000_0000);
      push_op(OP_RESERVE, 1'b1, 32'h0000_0000);
      push_op(OP_SUBMIT,  1'b1, 32'h0000_0000);
      push_op(OP_SUBMIT,  1'b1, 32'h0000_0010);
      push_op(OP_PEEK,    1'b1, 32'h8000_0000);
      push_op(OP_CONSUME, 1'b1, 32'h8000_0000);
      push_op(OP_CONSUME, 1'b1, 32'h0000_0000);
      wait_idle();

      // count clamps to 2 with a completion tail left beyond it: wrap, full, empty
      csr_write(CSR_ENTRY_COUNT, 32'd0);
      close_csr();
      push_op(OP_SUBMIT,  1'b1, plan_slot(1'b1, 1'b0));
      push_op(OP_RESERVE, 1'b1, 32'h0000_0000);
      push_op(OP_SUBMIT,  1'b1, plan_slot(1'b1, 1'b0));
      push_op(OP_CONSUME, 1'b1, plan_slot(1'b1, 1'b1));
      push_op(OP_CONSUME, 1'b1, plan_slot(1'b1, 1'b1));
      push_op(OP_SUBMIT,  1'b0, plan_slot(1'b0, 1'b0));
      push_op(OP_RESERVE, 1'b0, 32'hFFFF_FFFF);
      push_op(OP_SUBMIT,  1'b0, plan_slot(1'b0, 1'b0));
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         idle_pct = idle_menu[p % 4];
         val = count_menu[p];
         if (p % 2 == 1) val = val | ($urandom & ~32'h7FF);
         csr_write(CSR_ENTRY_COUNT, val);
         csr_write(CSR_SQ_BASE, (p % 5 == 4) ? $urandom : base_menu[p % 4]);
         csr_write(CSR_CQ_BASE, (p % 3 == 2) ? $urandom : base_menu[(p + 1) % 4]);
         csr_write(CSR_SQ_ENTRY_SIZE, (p % 7 == 6) ? $urandom_range(8191) : size_menu[p % 6]);
         csr_write(CSR_CQ_ENTRY_SIZE, size_menu[(p + 3) % 6]);
         csr_write(CSR_IDX_W'(5 + p % 3), $urandom);
         close_csr();
         repeat (PHASE_ITEMS / 4) plan_random_pair(bias_menu[p % 3]);
         // hold off until every outstanding result is back
         wait_idle();
         repeat (PHASE_ITEMS / 4) plan_random_pair(bias_menu[p % 3]);
         wait_idle();
      end

      $display("Run covered %0d items under %0d register settings, %0d results checked",
               items_sent, settings_used, replies_seen);
      $display("Result mix: %0d ok, %0d full, %0d empty, %0d address mismatch",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
               status_seen[ST_MISMATCH]);
      if (expected_replies.size() != 0)
         $display("ERROR %0d results never arrived", expected_replies.size());
      if (fail_count == 0 && expected_replies.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
